// ----- sv/keyed_weight_histogram_mode_macros.svh -----
// Assertion macros used by the histogram top-level RTL file.
`ifndef KEYED_WEIGHT_HISTOGRAM_MODE_MACROS_SVH
`define KEYED_WEIGHT_HISTOGRAM_MODE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/khm_pkg.sv -----
// Package: table size, derived widths and the control bundle sent to every cell.
package khm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 16;
    localparam int WGT_W         = 16;
    localparam int TOT_W         = 32;

    // Control broadcast from the sequencer to the row of cells
    typedef struct packed {
        logic             cmp;     // compare phase: latch key match
        logic             upd;     // update phase: add or allocate
        logic             clear;   // item starts a fresh table
        logic             alloc;   // no hit and room left: first free cell takes the key
        logic [KEY_W-1:0] font;
        logic [KEY_W-1:0] size;
        logic [WGT_W-1:0] weight;
    } t_cell_ctl;

endpackage

// ----- sv/khm_cell.sv -----
// One table entry: key, saturating count, used flag and match latch.
module khm_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  khm_pkg::t_cell_ctl                  i_ctl,
    input  logic                                i_prev_used,
    output logic                                o_used_eff,
    output logic                                o_hit,
    output logic                                o_touch,
    output logic [khm_pkg::TOT_W-1:0]           o_new_total
);

    logic                         r_used;
    logic                         r_hit;
    logic [khm_pkg::KEY_W-1:0]    r_font;
    logic [khm_pkg::KEY_W-1:0]    r_size;
    logic [khm_pkg::TOT_W-1:0]    r_total;

    logic                         w_alloc_me;
    logic [khm_pkg::TOT_W:0]      w_sum;
    logic [khm_pkg::TOT_W-1:0]    w_sat;

    // A start item empties the table before counting
    assign o_used_eff = r_used & ~i_ctl.clear;
    assign o_hit      = r_hit;

    // First free cell: left neighbor holds an entry, this one does not
    assign w_alloc_me = i_ctl.alloc & i_prev_used & ~o_used_eff;

    // Saturating add of the weight
    assign w_sum = {1'b0, r_total} + {{(khm_pkg::TOT_W + 1 - khm_pkg::WGT_W){1'b0}}, i_ctl.weight};
    assign w_sat = w_sum[khm_pkg::TOT_W] ? {khm_pkg::TOT_W{1'b1}} : w_sum[khm_pkg::TOT_W-1:0];

    assign o_touch     = i_ctl.upd & (r_hit | w_alloc_me);
    assign o_new_total = r_hit ? w_sat
                               : {{(khm_pkg::TOT_W - khm_pkg::WGT_W){1'b0}}, i_ctl.weight};

    // Used flag and match latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_hit <= o_used_eff && (r_font == i_ctl.font) && (r_size == i_ctl.size);
            end
            if (i_ctl.upd) begin
                r_used <= o_used_eff | w_alloc_me;
            end
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (w_alloc_me && i_ctl.upd) begin
            r_font <= i_ctl.font;
            r_size <= i_ctl.size;
        end
        if (o_touch) begin
            r_total <= o_new_total;
        end
    end

endmodule

// ----- sv/keyed_weight_histogram_mode.sv -----
// An accepted item steps through compare, update and top select before its result is
// registered. A new item is taken only after the last one has left top select; the
// compare-then-update pass through the cell row and top-entry select run in turn per item.
// The next item is taken while a result still waits at the output register.
// Reset (synchronous, active low): table empty, top entry index 0, no result pending.
// Top level: row of table cells plus the item sequencer and the running top entry.
`include "keyed_weight_histogram_mode_macros.svh"

module keyed_weight_histogram_mode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_start_set,
    input  logic [khm_pkg::KEY_W-1:0]         i_font_key,
    input  logic [khm_pkg::KEY_W-1:0]         i_size_key,
    input  logic [khm_pkg::WGT_W-1:0]         i_weight,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [khm_pkg::KEY_W-1:0]         o_top_font_key,
    output logic [khm_pkg::KEY_W-1:0]         o_top_size_key,
    output logic [khm_pkg::TOT_W-1:0]         o_top_total,
    output logic [khm_pkg::CNT_W-1:0]         o_entries_used,
    output logic                              o_dropped
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_TOP  = 2'd3;

    localparam int N = khm_pkg::TABLE_ENTRIES;

    logic [1:0]                   r_state, n_state;

    // Item held for the whole pass
    logic                         r_start;
    logic                         r_fresh;
    logic [khm_pkg::KEY_W-1:0]    r_font;
    logic [khm_pkg::KEY_W-1:0]    r_size;
    logic [khm_pkg::WGT_W-1:0]    r_weight;

    // Update-phase results
    logic                         r_touched;
    logic [khm_pkg::TOT_W-1:0]    r_sel_total;
    logic [khm_pkg::IDX_W-1:0]    r_sel_idx;
    logic [khm_pkg::CNT_W-1:0]    r_used_count;

    // Running top entry
    logic [khm_pkg::KEY_W-1:0]    r_top_font;
    logic [khm_pkg::KEY_W-1:0]    r_top_size;
    logic [khm_pkg::TOT_W-1:0]    r_top_total;
    logic [khm_pkg::IDX_W-1:0]    r_top_idx;

    // Output register
    logic                         r_out_valid;
    logic [khm_pkg::KEY_W-1:0]    r_out_font;
    logic [khm_pkg::KEY_W-1:0]    r_out_size;
    logic [khm_pkg::TOT_W-1:0]    r_out_total;
    logic [khm_pkg::CNT_W-1:0]    r_out_used;
    logic                         r_out_drop;

    khm_pkg::t_cell_ctl           w_ctl;
    logic [N-1:0]                 w_used_eff;
    logic [N-1:0]                 w_hit;
    logic [N-1:0]                 w_touch;
    logic [khm_pkg::TOT_W-1:0]    w_new_total [N];
    logic                         w_any_hit;
    logic                         w_full;
    logic                         w_touch_any;
    logic [khm_pkg::TOT_W-1:0]    w_sel_total;
    logic [khm_pkg::IDX_W-1:0]    w_sel_idx;
    logic                         w_take;
    logic                         w_accept;
    logic                         w_out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_TOP) && (!r_out_valid || i_out_ready);

    // Hit or full decides between add, allocate and drop
    assign w_any_hit = |w_hit;
    assign w_full    = w_used_eff[N-1];

    always_comb begin
        w_ctl.cmp    = (r_state == S_CMP);
        w_ctl.upd    = (r_state == S_UPD);
        w_ctl.clear  = r_start;
        w_ctl.alloc  = !w_any_hit && !w_full;
        w_ctl.font   = r_font;
        w_ctl.size   = r_size;
        w_ctl.weight = r_weight;
    end

    // Row of cells; each hands its used flag to the right neighbor
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic w_prev;
        if (g == 0) begin : g_first
            assign w_prev = 1'b1;
        end else begin : g_rest
            assign w_prev = w_used_eff[g-1];
        end
        khm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev_used (w_prev),
            .o_used_eff  (w_used_eff[g]),
            .o_hit       (w_hit[g]),
            .o_touch     (w_touch[g]),
            .o_new_total (w_new_total[g])
        );
    end

    // Gather the one touched cell: its new count and index
    always_comb begin
        w_sel_total = '0;
        w_sel_idx   = '0;
        for (int i = 0; i < N; i++) begin
            if (w_touch[i]) begin
                w_sel_total = w_sel_total | w_new_total[i];
                w_sel_idx   = w_sel_idx | khm_pkg::IDX_W'(i);
            end
        end
    end
    assign w_touch_any = |w_touch;

    // Counts only grow, so the touched entry either takes over or the top stays;
    // ties go to the lower index
    assign w_take = r_touched &&
                    (r_fresh || (r_sel_total > r_top_total) ||
                     ((r_sel_total == r_top_total) && (r_sel_idx <= r_top_idx)));

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = S_TOP;
            S_TOP:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used_count <= '0;
            r_top_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                if (r_start) begin
                    r_used_count <= khm_pkg::CNT_W'(w_ctl.alloc);
                end else begin
                    r_used_count <= r_used_count + khm_pkg::CNT_W'(w_ctl.alloc);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (w_take) begin
                    r_top_idx <= r_sel_idx;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start  <= i_start_set;
            r_fresh  <= i_start_set || (r_used_count == '0);
            r_font   <= i_font_key;
            r_size   <= i_size_key;
            r_weight <= i_weight;
        end
        if (r_state == S_UPD) begin
            r_touched   <= w_touch_any;
            r_sel_total <= w_sel_total;
            r_sel_idx   <= w_sel_idx;
        end
        if (w_out_load) begin
            if (w_take) begin
                r_top_font  <= r_font;
                r_top_size  <= r_size;
                r_top_total <= r_sel_total;
            end
            r_out_font  <= w_take ? r_font : r_top_font;
            r_out_size  <= w_take ? r_size : r_top_size;
            r_out_total <= w_take ? r_sel_total : r_top_total;
            r_out_used  <= r_used_count;
            r_out_drop  <= !r_touched;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_top_font_key = r_out_font;
    assign o_top_size_key = r_out_size;
    assign o_top_total    = r_out_total;
    assign o_entries_used = r_out_used;
    assign o_dropped      = r_out_drop;

    // Checks
    `KHM_ASSERT_NOW(a_touch_onehot, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_touch),
        "more than one cell touched by an item")
    `KHM_ASSERT_NOW(a_hit_blocks_alloc, i_clk, i_rst_n, (r_state == S_UPD) && w_any_hit,
        w_touch == w_hit, "a hit item also allocated a cell")
    `KHM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_used_count <= khm_pkg::CNT_W'(N), "entry count beyond table size")
    `KHM_ASSERT_NOW(a_drop_full, i_clk, i_rst_n, r_out_valid && r_out_drop,
        r_out_used == khm_pkg::CNT_W'(N), "item dropped with room left in the table")
    `KHM_ASSERT_NEXT(a_cmp_to_upd, i_clk, i_rst_n, r_state == S_CMP, r_state == S_UPD,
        "compare phase not followed by update")

endmodule
